// ===== src/integer_matrix_multiply_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Integer matrix multiply unit assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_MACROS_SVH

`ifndef SYNTH
`define IMM_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("imm assertion failed");
`define IMM_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("imm assertion failed");
`else
`define IMM_ASSERT_IMPL(lbl, ant, cons)
`define IMM_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

// ===== src/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiply unit.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int unsigned IMM_MAX_DIM   = 64;
  localparam int unsigned IMM_ELEM_BITS = 16;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned SUM_W   = 32;

  localparam logic [CFG_W-1:0] CFG_DIM_RST = CFG_W'(64);

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_A    = 2'd0,
    REQ_WR_B    = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic finish;
  } imm_cmd_t;

  typedef struct packed {
    logic range_err;
    logic n_zero;
    logic last_k;
    logic pipe_busy;
    logic out_free;
  } imm_stat_t;

endpackage

// ===== src/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/imm_ctrl.sv =====
// ----------------------------------------------------------------------------
// imm_ctrl
// Request sequencer: decodes beats and steps the dot product walk.
// ----------------------------------------------------------------------------
module imm_ctrl
  import imm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [REQ_W-1:0] req_type,
  input  imm_stat_t        stat,
  output logic             in_tready,
  output imm_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (req_type_t'(req_type))
            REQ_WR_A: cmd.wr_a = 1'b1;
            REQ_WR_B: cmd.wr_b = 1'b1;
            REQ_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = (stat.range_err || stat.n_zero) ? S_DONE : S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.last_k) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/imm_dpath.sv =====
// ----------------------------------------------------------------------------
// imm_dpath
// Matrix stores, config registers, multiply-accumulate and result register.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_unit_macros.svh"

module imm_dpath
  import imm_pkg::*;
#(
  parameter int unsigned MAX_DIM   = IMM_MAX_DIM,
  parameter int unsigned ELEM_BITS = IMM_ELEM_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  imm_cmd_t               cmd,
  output imm_stat_t              stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DW-1:0]    m_c, n_c, p_c;

  logic [IDX_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_val;
  logic             wr_ok;
  logic [31:0]      wr_addr_w;
  logic [ELEM_BITS-1:0] wr_data;

  logic [IDX_W-1:0] row_r, col_r;
  logic             err_r;
  logic [DW-1:0]    k_r;
  logic [31:0]      a_addr_w, b_addr_w;
  logic [ELEM_BITS-1:0] a_rd, b_rd;
  logic signed [31:0]   a_ext, b_ext;
  logic             rd_v_r, mul_v_r;
  logic [SUM_W-1:0] mul_r, mul_nxt;
  logic [SUM_W-1:0] acc_r;

  logic             out_v_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_status_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_DIM_RST;
      inner_dim_r <= CFG_DIM_RST;
      cols_b_r    <= CFG_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // values above the store size act as the store size
  assign m_c = (32'(rows_a_r)    > MAX_DIM) ? DW'(MAX_DIM) : DW'(rows_a_r);
  assign n_c = (32'(inner_dim_r) > MAX_DIM) ? DW'(MAX_DIM) : DW'(inner_dim_r);
  assign p_c = (32'(cols_b_r)    > MAX_DIM) ? DW'(MAX_DIM) : DW'(cols_b_r);

  assign in_row = in_tdata[IDX_W-1:0];
  assign in_col = in_tdata[2*IDX_W-1:IDX_W];
  assign in_val = in_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

  assign wr_ok     = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign wr_addr_w = 32'(in_row) * 32'(MAX_DIM) + 32'(in_col);
  assign wr_data   = ELEM_BITS'(32'(signed'(in_val)));

  assign a_addr_w = 32'(row_r) * 32'(MAX_DIM) + 32'(k_r);
  assign b_addr_w = 32'(k_r) * 32'(MAX_DIM) + 32'(col_r);

  imm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk     (clk),
    .we      (cmd.wr_a && wr_ok),
    .wr_addr (wr_addr_w[AW-1:0]),
    .wr_data (wr_data),
    .re      (cmd.issue),
    .rd_addr (a_addr_w[AW-1:0]),
    .rd_data (a_rd)
  );

  imm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk     (clk),
    .we      (cmd.wr_b && wr_ok),
    .wr_addr (wr_addr_w[AW-1:0]),
    .wr_data (wr_data),
    .re      (cmd.issue),
    .rd_addr (b_addr_w[AW-1:0]),
    .rd_data (b_rd)
  );

  assign a_ext   = 32'(signed'(a_rd));
  assign b_ext   = 32'(signed'(b_rd));
  assign mul_nxt = a_ext * b_ext;

  // walk: issue -> ram read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_row;
      col_r <= in_col;
      err_r <= stat.range_err;
      k_r   <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.issue) begin
        k_r <= DW'(k_r + 1'b1);
      end
      if (mul_v_r) begin
        acc_r <= acc_r + mul_r;
      end
    end
    if (rd_v_r) begin
      mul_r <= mul_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.finish) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sum_r    <= err_r ? '0 : acc_r;
      out_status_r <= err_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_status_r;

  assign stat.range_err = (32'(in_row) >= 32'(m_c)) || (32'(in_col) >= 32'(p_c));
  assign stat.n_zero    = (n_c == '0);
  assign stat.last_k    = (DW'(k_r + 1'b1) == n_c);
  assign stat.pipe_busy = rd_v_r || mul_v_r;
  assign stat.out_free  = !out_v_r || out_tready;

  `IMM_ASSERT_IMPL(a_k_in_range, cmd.issue, k_r < n_c)
  `IMM_ASSERT_NEXT(a_read_to_mul, rd_v_r, mul_v_r)
  `IMM_ASSERT_IMPL(a_load_free, cmd.finish, !out_v_r || out_tready)
  `IMM_ASSERT_IMPL(a_err_zero, out_v_r && out_status_r, out_sum_r == '0)

endmodule

// ===== src/integer_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Two signed matrix stores loaded by write beats; compute beats return one
// wrapped 32-bit dot product of a row of A and a column of B.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/tready     tuser: req_type; tdata: row, col, value
// out_     out  out_tvalid/tready    tdata: dot_sum;  tuser: status
// cfg_     in   cfg_we               cfg_addr: register, cfg_wdata: value
//
// Write beats are taken while idle. A compute beat walks inner_dim steps:
// one multiply-accumulate per cycle, limited by the single read port of each
// store, plus accept, RAM read, multiply, accumulate and result load steps.
// Out-of-range or zero-length computes skip the walk and go straight to the
// result load. No clearing pass after reset. A stalled result holds the next
// compute at its final step; write beats still flow until then.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit
  import imm_pkg::*;
#(
  parameter int unsigned MAX_DIM   = IMM_MAX_DIM,
  parameter int unsigned ELEM_BITS = IMM_ELEM_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row_index, col_index, element_value
  input  logic [REQ_W-1:0]       in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // dot_sum
  output logic                   out_tuser   // status
);

  imm_cmd_t  cmd;
  imm_stat_t stat;

  imm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  imm_dpath #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/integer_matrix_multiply_unit_test.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit_test
// Loads the A and B stores with write beats and checks every compute result
// against a shadow copy of both stores and the dimension registers. Covers
// element extremes, wraparound, out-of-range and zero-size cases, clamped
// registers, random traffic under varying idle mixes and output back-pressure.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import imm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STORE_DEPTH  = IMM_MAX_DIM * IMM_MAX_DIM;
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES   = 80;

  typedef struct packed {
    logic             status;
    logic [SUM_W-1:0] sum;
  } dot_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_A_W-1:0]     cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // row_index, col_index, element_value, pad
  logic [REQ_W-1:0]       in_tuser = '0;   // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // dot_sum
  logic                   out_tuser;       // status

  // shadow of the block
  logic signed [VAL_W-1:0] a_mat [STORE_DEPTH];
  logic signed [VAL_W-1:0] b_mat [STORE_DEPTH];
  bit                      a_written [STORE_DEPTH];
  bit                      b_written [STORE_DEPTH];
  logic [CFG_W-1:0]        rows_reg  = CFG_DIM_RST;
  logic [CFG_W-1:0]        inner_reg = CFG_DIM_RST;
  logic [CFG_W-1:0]        cols_reg  = CFG_DIM_RST;

  dot_result_t pending_sums [$];
  dot_result_t want_sum;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;
  int beats_sent    = 0;
  int noise_sent    = 0;
  int sums_checked  = 0;
  int settings_used = 0;
  int errors        = 0;

  integer_matrix_multiply_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sum %h status %0b", $time, out_tdata, out_tuser);
      end else begin
        want_sum = pending_sums.pop_front();
        sums_checked++;
        if (want_sum.sum !== out_tdata) begin
          errors++;
          $display("%0t: dot_sum expected %h actual %h", $time, want_sum.sum, out_tdata);
        end
        if (want_sum.status !== out_tuser) begin
          errors++;
          $display("%0t: status expected %0b actual %0b", $time, want_sum.status, out_tuser);
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("FAIL integer_matrix_multiply_unit");
    $finish;
  end

  function automatic int eff_dim(logic [CFG_W-1:0] r);
    return (r > IMM_MAX_DIM) ? IMM_MAX_DIM : int'(r);
  endfunction

  function automatic dot_result_t predict_dot(int row, int col);
    dot_result_t       r;
    logic signed [31:0] prod;
    logic [SUM_W-1:0]   acc;
    r   = '0;
    acc = '0;
    if (row >= eff_dim(rows_reg) || col >= eff_dim(cols_reg)) begin
      r.status = 1'b1;
      return r;
    end
    for (int k = 0; k < eff_dim(inner_reg); k++) begin
      prod = a_mat[row * IMM_MAX_DIM + k] * b_mat[k * IMM_MAX_DIM + col];
      acc  = acc + prod;
    end
    r.sum = acc;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return VAL_W'($urandom_range(16'hffff));
    endcase
  endfunction

  // mostly low indices so operand rows and columns get reused
  function automatic int pick_index(int limit);
    int lim;
    lim = (limit < 1) ? 1 : limit;
    if ($urandom_range(3) != 0) return $urandom_range(((lim < 3) ? lim : 3) - 1);
    return $urandom_range(lim - 1);
  endfunction

  task automatic apply_beat(logic [REQ_W-1:0] kind, int row, int col,
                            logic [VAL_W-1:0] value);
    case (kind)
      REQ_WR_A: begin
        a_mat[row * IMM_MAX_DIM + col] = value;
        a_written[row * IMM_MAX_DIM + col] = 1'b1;
      end
      REQ_WR_B: begin
        b_mat[row * IMM_MAX_DIM + col] = value;
        b_written[row * IMM_MAX_DIM + col] = 1'b1;
      end
      REQ_COMPUTE: pending_sums = {pending_sums, predict_dot(row, col)};
      default: ;
    endcase
  endtask

  // called and returns at a falling edge
  task automatic send_beat(logic [REQ_W-1:0] kind, int row, int col,
                           logic [VAL_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(1, 6)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {4'b0, value, IDX_W'(col), IDX_W'(row)};
    do @(posedge clk); while (!in_tready);
    apply_beat(kind, row, col, value);
    if (kind == REQ_UNUSED) noise_sent++;
    else beats_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ROWS_A:    rows_reg  = CFG_W'(value);
      CFG_INNER_DIM: inner_reg = CFG_W'(value);
      CFG_COLS_B:    cols_reg  = CFG_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_dims(int m, int n, int p);
    wait_drain();
    write_reg(CFG_ROWS_A, m);
    write_reg(CFG_INNER_DIM, n);
    write_reg(CFG_COLS_B, p);
    settings_used++;
  endtask

  // writes every operand a compute would read that has never been written
  task automatic fill_operands(int row, int col);
    if (row < eff_dim(rows_reg) && col < eff_dim(cols_reg)) begin
      for (int k = 0; k < eff_dim(inner_reg); k++) begin
        if (!a_written[row * IMM_MAX_DIM + k]) send_beat(REQ_WR_A, row, k, rand_elem());
        if (!b_written[k * IMM_MAX_DIM + col]) send_beat(REQ_WR_B, k, col, rand_elem());
      end
    end
  endtask

  task automatic compute_at(int row, int col);
    fill_operands(row, col);
    send_beat(REQ_COMPUTE, row, col, rand_elem());
  endtask

  task automatic run_random_traffic(int count);
    int first;
    int pick;
    first = beats_sent;
    while (beats_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 50)
        compute_at(pick_index(eff_dim(rows_reg)), pick_index(eff_dim(cols_reg)));
      else if (pick < 60)
        compute_at($urandom_range(63), $urandom_range(63));
      else if (pick < 72)
        send_beat(REQ_WR_A, $urandom_range(63), $urandom_range(63), rand_elem());
      else if (pick < 84)
        send_beat(REQ_WR_B, $urandom_range(63), $urandom_range(63), rand_elem());
      else if (pick < 92)
        send_beat(REQ_WR_A, pick_index(4), pick_index(eff_dim(inner_reg)), rand_elem());
      else
        send_beat(REQ_UNUSED, $urandom_range(63), $urandom_range(63), rand_elem());
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 23;
    recv_idle_pct = 73;
    set_dims(1, 1, 1);
    send_beat(REQ_WR_A, 0, 0, 16'h7fff);
    send_beat(REQ_WR_B, 0, 0, 16'h7fff);
    send_beat(REQ_COMPUTE, 0, 0, 16'h0000);
    send_beat(REQ_WR_A, 0, 0, 16'h8000);
    send_beat(REQ_WR_B, 0, 0, 16'h8000);
    send_beat(REQ_COMPUTE, 0, 0, 16'hffff);
    send_beat(REQ_WR_B, 0, 0, 16'h7fff);
    send_beat(REQ_COMPUTE, 0, 0, 16'h0000);
    send_beat(REQ_COMPUTE, 1, 0, 16'h0000);
    send_beat(REQ_COMPUTE, 0, 63, 16'h0000);
    send_beat(REQ_COMPUTE, 63, 63, 16'h0000);
    send_beat(REQ_UNUSED, 0, 0, 16'hffff);
    send_beat(REQ_COMPUTE, 0, 0, 16'h0000);
    send_beat(REQ_WR_A, 63, 63, 16'h1234);
    set_dims(0, 0, 0);
    send_beat(REQ_COMPUTE, 0, 0, 16'h0000);
    set_dims(127, 0, 127);
    send_beat(REQ_COMPUTE, 63, 63, 16'h0000);
    send_beat(REQ_COMPUTE, 0, 0, 16'h0000);
    set_dims(64, 1, 64);
    send_beat(REQ_WR_B, 0, 63, 16'hffff);
    send_beat(REQ_WR_A, 63, 0, 16'h7fff);
    send_beat(REQ_COMPUTE, 63, 63, 16'h0000);
  endtask

  task automatic test_sender_light_receiver_heavy();
    send_idle_pct = 23;
    recv_idle_pct = 73;
    set_dims(8, 8, 8);
    run_random_traffic(200);
  endtask

  task automatic test_sender_heavy_receiver_light();
    send_idle_pct = 73;
    recv_idle_pct = 23;
    set_dims(64, 64, 64);
    run_random_traffic(250);
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_dims(127, 5, 1);
    run_random_traffic(120);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_dims(4, 8, 4);
    for (int r = 0; r < 4; r++) fill_operands(r, r);
    for (int c = 0; c < 4; c++) fill_operands(0, c);
    for (int r = 1; r < 4; r++) fill_operands(r, 0);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) fill_operands(r, c);
    stall_left = 300;
    repeat (40) send_beat(REQ_COMPUTE, $urandom_range(3), $urandom_range(3), rand_elem());
    wait_drain();
    run_random_traffic(40);
  endtask

  task automatic test_small_shapes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_dims(1, 1, 1);
    run_random_traffic(60);
    repeat (3) begin
      set_dims($urandom_range(1, 8), $urandom_range(0, 8), $urandom_range(1, 8));
      run_random_traffic(40);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_sender_light_receiver_heavy();
    test_sender_heavy_receiver_light();
    test_no_idle();
    test_output_backpressure();
    test_small_shapes();
    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Covered %0d load and compute beats plus %0d ignored beats, %0d sums checked",
             beats_sent, noise_sent, sums_checked);
    $display("over %0d dimension settings, idle mixes and a long output stall",
             settings_used);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("PASS integer_matrix_multiply_unit");
    end else begin
      $display("FAIL integer_matrix_multiply_unit");
    end
    $finish;
  end

endmodule
